// ----- sv/ptpf_pkg.sv -----
// Shared widths, types and codes for the prime test and factor unit.
package ptpf_pkg;

  localparam int unsigned VALUE_BITS  = 16;
  localparam int unsigned VALUE_W     = 16;
  localparam int unsigned FACTOR_W    = 16;
  localparam int unsigned MAX_RESULTS = 6;

  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int unsigned SQ_W        = VALUE_BITS + 2;
  localparam int unsigned DIV_CNT_W   = $clog2(VALUE_BITS + 1);
  localparam int unsigned S_TDATA_W   = ((VALUE_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W   = ((FACTOR_W + 1 + 7) / 8) * 8;

  typedef logic [VALUE_BITS-1:0] num_t;

  typedef enum logic {
    MODE_PRIME  = 1'b0,
    MODE_FACTOR = 1'b1
  } mode_e;

  typedef struct packed {
    logic start;
    num_t dividend;
    num_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    num_t quot;
    num_t rem;
  } div_rsp_t;

endpackage

// ----- sv/ptpf_div.sv -----
// Restoring divider, one quotient bit per cycle.
module ptpf_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ptpf_pkg::div_req_t req_i,
  output ptpf_pkg::div_rsp_t rsp_o
);
  import ptpf_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  num_t                 quot_q, quot_d;
  num_t                 rem_q, rem_d;
  num_t                 dsr_q, dsr_d;
  logic [VALUE_BITS:0]  shifted;
  logic [VALUE_BITS:0]  trial;

  // partial remainder stays below the divisor, so one extra bit is enough
  assign shifted = {rem_q, quot_q[VALUE_BITS-1]};
  assign trial   = shifted - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = DIV_CNT_W'(VALUE_BITS);
      quot_d = req_i.dividend;
      rem_d  = '0;
      dsr_d  = req_i.divisor;
    end else if (busy_q) begin
      quot_d = {quot_q[VALUE_BITS-2:0], ~trial[VALUE_BITS]};
      rem_d  = trial[VALUE_BITS] ? shifted[VALUE_BITS-1:0] : trial[VALUE_BITS-1:0];
      cnt_d  = cnt_q - 1'b1;
      if (cnt_q == DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign rsp_o = '{done: done_q, quot: quot_q, rem: rem_q};

endmodule

// ----- sv/ptpf_ctrl.sv -----
// Sequencer: walks trial divisors, collects factors, drives the output register.
module ptpf_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          in_mode_i,
  input  logic [ptpf_pkg::VALUE_W-1:0]  in_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ptpf_pkg::FACTOR_W-1:0] out_factor_o,
  output logic                          out_found_o,
  output logic                          out_is_prime_o,
  output logic                          out_last_o,
  output ptpf_pkg::div_req_t            div_req_o,
  input  ptpf_pkg::div_rsp_t            div_rsp_i
);
  import ptpf_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_PUSH,
    ST_FIN
  } state_e;

  state_e              state_q, state_d;
  mode_e               mode_q, mode_d;
  num_t                n_q, n_d;
  num_t                d_q, d_d;
  logic [SQ_W-1:0]     sq_q, sq_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  num_t                pend_q, pend_d;
  logic                pend_vld_q, pend_vld_d;
  logic                reduce_q, reduce_d;
  logic                hit_q, hit_d;
  logic                start_q, start_d;
  logic                out_vld_q, out_vld_d;
  logic [FACTOR_W-1:0] out_factor_q, out_factor_d;
  logic                out_found_q, out_found_d;
  logic                out_prime_q, out_prime_d;
  logic                out_last_q, out_last_d;
  logic                out_free;
  logic                more;
  logic                tail;

  assign out_free = !out_vld_q || out_ready_i;
  assign more     = (sq_q <= SQ_W'(n_q)) && (cnt_q < CNT_W'(MAX_RESULTS));
  // leftover cofactor above one is itself a prime factor
  assign tail     = (n_q > num_t'(1)) && (cnt_q < CNT_W'(MAX_RESULTS));

  always_comb begin
    state_d      = state_q;
    mode_d       = mode_q;
    n_d          = n_q;
    d_d          = d_q;
    sq_d         = sq_q;
    cnt_d        = cnt_q;
    pend_d       = pend_q;
    pend_vld_d   = pend_vld_q;
    reduce_d     = reduce_q;
    hit_d        = hit_q;
    start_d      = 1'b0;
    out_vld_d    = out_vld_q && !out_ready_i;
    out_factor_d = out_factor_q;
    out_found_d  = out_found_q;
    out_prime_d  = out_prime_q;
    out_last_d   = out_last_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          mode_d     = mode_e'(in_mode_i);
          n_d        = VALUE_BITS'(in_value_i);
          d_d        = num_t'(2);
          sq_d       = SQ_W'(4);
          cnt_d      = '0;
          pend_vld_d = 1'b0;
          reduce_d   = 1'b0;
          hit_d      = 1'b0;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (more) begin
          start_d = 1'b1;
          state_d = ST_DIV;
        end else begin
          state_d = ST_FIN;
        end
      end
      ST_DIV: begin
        if (div_rsp_i.done) begin
          if (div_rsp_i.rem == '0) begin
            if (mode_q == MODE_PRIME) begin
              hit_d   = 1'b1;
              state_d = ST_FIN;
            end else begin
              n_d = div_rsp_i.quot;
              if (reduce_q) begin
                start_d = 1'b1;   // keep dividing out the same prime
              end else begin
                state_d = ST_PUSH;
              end
            end
          end else begin
            reduce_d = 1'b0;
            d_d      = d_q + 1'b1;
            // (d+1)^2 = d^2 + 2d + 1
            sq_d     = sq_q + SQ_W'({d_q, 1'b1});
            state_d  = ST_CHECK;
          end
        end
      end
      ST_PUSH: begin
        if (!pend_vld_q || out_free) begin
          if (pend_vld_q) begin
            out_vld_d    = 1'b1;
            out_factor_d = FACTOR_W'(pend_q);
            out_found_d  = 1'b1;
            out_prime_d  = 1'b0;
            out_last_d   = 1'b0;
          end
          pend_d     = d_q;
          pend_vld_d = 1'b1;
          cnt_d      = cnt_q + 1'b1;
          reduce_d   = 1'b1;
          start_d    = 1'b1;
          state_d    = ST_DIV;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          priority if (mode_q == MODE_PRIME) begin
            out_factor_d = '0;
            out_found_d  = 1'b0;
            out_prime_d  = !hit_q && (n_q >= num_t'(2));
            out_last_d   = 1'b1;
            state_d      = ST_IDLE;
          end else if (pend_vld_q && tail) begin
            out_factor_d = FACTOR_W'(pend_q);
            out_found_d  = 1'b1;
            out_prime_d  = 1'b0;
            out_last_d   = 1'b0;
            pend_vld_d   = 1'b0;
          end else if (pend_vld_q) begin
            out_factor_d = FACTOR_W'(pend_q);
            out_found_d  = 1'b1;
            out_prime_d  = 1'b0;
            out_last_d   = 1'b1;
            state_d      = ST_IDLE;
          end else begin
            out_factor_d = tail ? FACTOR_W'(n_q) : '0;
            out_found_d  = tail;
            out_prime_d  = 1'b0;
            out_last_d   = 1'b1;
            state_d      = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      pend_vld_q <= 1'b0;
      reduce_q   <= 1'b0;
      hit_q      <= 1'b0;
      start_q    <= 1'b0;
      out_vld_q  <= 1'b0;
      cnt_q      <= '0;
    end else begin
      state_q    <= state_d;
      pend_vld_q <= pend_vld_d;
      reduce_q   <= reduce_d;
      hit_q      <= hit_d;
      start_q    <= start_d;
      out_vld_q  <= out_vld_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q       <= mode_d;
    n_q          <= n_d;
    d_q          <= d_d;
    sq_q         <= sq_d;
    pend_q       <= pend_d;
    out_factor_q <= out_factor_d;
    out_found_q  <= out_found_d;
    out_prime_q  <= out_prime_d;
    out_last_q   <= out_last_d;
  end

  assign in_ready_o     = (state_q == ST_IDLE);
  assign out_valid_o    = out_vld_q;
  assign out_factor_o   = out_factor_q;
  assign out_found_o    = out_found_q;
  assign out_is_prime_o = out_prime_q;
  assign out_last_o     = out_last_q;
  assign div_req_o      = '{start: start_q, dividend: n_q, divisor: d_q};

endmodule

// ----- sv/prime_test_and_prime_factors_unit.sv -----
// Top level of the trial-division prime test and distinct prime factor unit.
//
// Input stream: one word per job. tdata carries the value, tuser the mode
// (0 = primality test, 1 = list distinct prime factors).
// Output stream: mode 0 gives one word with tlast set, is_prime high for a
// prime. Mode 1 gives one word per distinct prime factor in ascending order,
// tlast on the final one; a value below two gives a single word with found = 0.
//
// Throughput: one job at a time; s_axis_tready_o is high only when idle.
// Every trial divisor d (from 2 while d*d <= n) costs one pass through the
// shared restoring divider, and each extra division that strips a repeated
// factor costs another pass. A prime near 65535 takes 254 trial divisors;
// values below four need no division at all.
//
// Results leave through a one-word output register. If the receiver stalls,
// the sequencer holds when it has the next word ready and resumes once the
// register drains. The last word may still wait in that register while a
// new job is accepted.
// Reset (rst_ni low, asynchronous) returns the sequencer to idle and drops
// m_axis_tvalid_o; nothing is carried from one job to the next.
module prime_test_and_prime_factors_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [ptpf_pkg::S_TDATA_W-1:0] s_axis_tdata_i,  // [15:0] value
  input  logic                           s_axis_tuser_i,  // [0] mode
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [ptpf_pkg::M_TDATA_W-1:0] m_axis_tdata_o,  // [15:0] factor, [16] is_prime
  output logic                           m_axis_tuser_o,  // [0] found
  output logic                           m_axis_tlast_o
);
  import ptpf_pkg::*;

  div_req_t            div_req;
  div_rsp_t            div_rsp;
  logic [FACTOR_W-1:0] factor;
  logic                is_prime;

  ptpf_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid_i),
    .in_ready_o     (s_axis_tready_o),
    .in_mode_i      (s_axis_tuser_i),
    .in_value_i     (s_axis_tdata_i[VALUE_W-1:0]),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .out_factor_o   (factor),
    .out_found_o    (m_axis_tuser_o),
    .out_is_prime_o (is_prime),
    .out_last_o     (m_axis_tlast_o),
    .div_req_o      (div_req),
    .div_rsp_i      (div_rsp)
  );

  // shared divider: n / d for every trial and every strip of a found factor
  ptpf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // pad bits above is_prime are zero
  assign m_axis_tdata_o = M_TDATA_W'({is_prime, factor});

endmodule

// ----- sv/ptpf_chk.sv -----
// Port-level checks for the prime test and factor unit, bound to the top level.
module ptpf_chk (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [ptpf_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  input logic                           m_axis_tuser_o,
  input logic                           m_axis_tlast_o
);
  import ptpf_pkg::*;

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("output word changed while stalled");

  // a job occupies the unit for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("ready stayed high after accepting a job");

  // a factor word never also claims primality
  a_found_not_prime: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> !m_axis_tdata_o[FACTOR_W])
    else $error("found and is_prime both set");

  // no factor means a zero factor field on a final word
  a_empty_factor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o |->
      (m_axis_tdata_o[FACTOR_W-1:0] == '0) && m_axis_tlast_o)
    else $error("word without a factor is not a zero final word");

  // any reported factor is at least two
  a_factor_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> (m_axis_tdata_o[FACTOR_W-1:0] > FACTOR_W'(1)))
    else $error("reported factor below two");

endmodule

bind prime_test_and_prime_factors_unit ptpf_chk u_ptpf_chk (.*);

// ----- tb/prime_test_and_prime_factors_unit_test.sv -----
// Self-checking testbench for the prime test and distinct prime factor unit.
module prime_test_and_prime_factors_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ptpf_pkg::*;

  // One output word as seen on the master side.
  typedef struct packed {
    logic [FACTOR_W-1:0] factor;
    logic                found;
    logic                is_prime;
    logic                last;
  } factor_word_t;

  // Directed stimulus row; 'typed' rows carry their answer, the rest go
  // through the trial-division predictor.
  typedef struct packed {
    mode_e        mode;
    num_t         value;
    logic         typed;
    factor_word_t word;
  } stim_row_t;

  localparam int unsigned N_DIRECTED   = 22;
  localparam int unsigned RANDOM_JOBS  = 118;
  localparam int unsigned TOTAL_JOBS   = N_DIRECTED + RANDOM_JOBS;
  localparam int unsigned CALM_JOBS    = 20;         // tail with no idling
  localparam int unsigned HOLD_AT      = 30;         // jobs taken before the long hold
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned DRAIN_CYCLES = 64;
  // Worst job is a prime near 65535, plus up to 6 words each held by a stall
  // and a gap before the next job; the limit is about four times what 140 jobs need.
  localparam int unsigned CYCLE_LIMIT  = 3_000_000;

  localparam factor_word_t IS_PRIME_W  = '{16'd0, 1'b0, 1'b1, 1'b1};
  localparam factor_word_t NOT_PRIME_W = '{16'd0, 1'b0, 1'b0, 1'b1};
  localparam factor_word_t NO_FACTOR_W = '{16'd0, 1'b0, 1'b0, 1'b1};
  localparam factor_word_t UNTYPED_W   = '0;

  localparam int unsigned SMALL_PRIMES [10] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29};

  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{MODE_PRIME,  16'd0,     1'b1, NOT_PRIME_W},  // zero and one are not prime
    '{MODE_PRIME,  16'd1,     1'b1, NOT_PRIME_W},
    '{MODE_PRIME,  16'd2,     1'b1, IS_PRIME_W},   // smallest prime
    '{MODE_PRIME,  16'd3,     1'b1, IS_PRIME_W},
    '{MODE_PRIME,  16'd4,     1'b1, NOT_PRIME_W},
    '{MODE_PRIME,  16'd25,    1'b1, NOT_PRIME_W},  // square of a prime
    '{MODE_PRIME,  16'd65535, 1'b1, NOT_PRIME_W},  // all ones
    '{MODE_PRIME,  16'd65521, 1'b1, IS_PRIME_W},   // largest 16-bit prime
    '{MODE_PRIME,  16'hAAAA,  1'b1, NOT_PRIME_W},
    '{MODE_FACTOR, 16'd0,     1'b1, NO_FACTOR_W},  // below two: single empty word
    '{MODE_FACTOR, 16'd1,     1'b1, NO_FACTOR_W},
    '{MODE_FACTOR, 16'd2,     1'b0, UNTYPED_W},
    '{MODE_FACTOR, 16'd3,     1'b0, UNTYPED_W},
    '{MODE_FACTOR, 16'd4,     1'b0, UNTYPED_W},
    '{MODE_FACTOR, 16'd49,    1'b0, UNTYPED_W},
    '{MODE_FACTOR, 16'd32768, 1'b0, UNTYPED_W},    // power of two
    '{MODE_FACTOR, 16'd30030, 1'b0, UNTYPED_W},    // six distinct primes
    '{MODE_FACTOR, 16'd65535, 1'b0, UNTYPED_W},
    '{MODE_FACTOR, 16'd65521, 1'b0, UNTYPED_W},    // large prime, full scan
    '{MODE_FACTOR, 16'd65534, 1'b0, UNTYPED_W},
    '{MODE_FACTOR, 16'd65498, 1'b0, UNTYPED_W},    // 2 x large prime remainder
    '{MODE_FACTOR, 16'h5555,  1'b0, UNTYPED_W}
  };

  logic clk_i;
  logic rst_ni = 1'b0;

  // Slave side driven by the job sender
  logic                 s_tvalid = 1'b0;
  logic                 s_axis_tready_o;
  logic [S_TDATA_W-1:0] s_tdata  = '0;      // [15:0] value
  logic                 s_tuser  = 1'b0;    // [0] mode

  // Master side sampled by the word checker
  logic                 m_axis_tvalid_o;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata_o;     // [15:0] factor, [16] is_prime
  logic                 m_axis_tuser_o;     // [0] found
  logic                 m_axis_tlast_o;

  factor_word_t due_words [$];   // words still owed by the block, oldest first
  int unsigned  jobs_taken = 0;
  int unsigned  errors     = 0;
  int unsigned  cycles     = 0;
  bit           calm       = 1'b0;

  prime_test_and_prime_factors_unit i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  initial begin : reset_seq
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin : watchdog
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Trial division: queue the words one job should produce.
  function automatic void trial_divide(mode_e mode, num_t value);
    factor_word_t w;
    int unsigned  n;
    int unsigned  d;
    bit           composite;
    int unsigned  primes [$];
    n = value;
    w = '0;
    w.last = 1'b1;
    if (mode == MODE_PRIME) begin
      composite = (n < 2);
      for (d = 2; d * d <= n; d++) begin
        if (n % d == 0) composite = 1'b1;
      end
      w.is_prime = !composite;
      due_words.push_back(w);
      return;
    end
    if (n < 2) begin
      due_words.push_back(w);
      return;
    end
    // strip each prime as found, so the list comes out ascending
    for (d = 2; d * d <= n && primes.size() < MAX_RESULTS; d++) begin
      if (n % d == 0) begin
        primes.push_back(d);
        while (n % d == 0) n = n / d;
      end
    end
    if (n > 1 && primes.size() < MAX_RESULTS) primes.push_back(n);
    foreach (primes[k]) begin
      w.factor = FACTOR_W'(primes[k]);
      w.found  = 1'b1;
      w.last   = (k == primes.size() - 1);
      due_words.push_back(w);
    end
  endfunction

  // Job sender: directed rows, then random jobs. Drives at the falling edge,
  // sees acceptance at the rising edge.
  initial begin : sender
    stim_row_t   row;
    int unsigned v;
    int unsigned pick;
    wait (rst_ni);
    @(negedge clk_i);
    for (int i = 0; i < TOTAL_JOBS; i++) begin
      if (i < N_DIRECTED) begin
        row = DIRECTED_ROWS[i];
      end else begin
        row.typed = 1'b0;
        row.word  = UNTYPED_W;
        row.mode  = mode_e'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0: v = $urandom_range(0, 255);
          1: v = $urandom_range(0, 65535);
          2: begin
            // product of small primes: often several factors per job
            v = 1;
            repeat ($urandom_range(1, 8)) begin
              pick = SMALL_PRIMES[$urandom_range(0, 9)];
              if (v * pick <= 65535) v = v * pick;
            end
          end
          default: v = $urandom_range(0, 1) ? 65535 - $urandom_range(0, 40)
                                            : $urandom_range(0, 3);
        endcase
        row.value = num_t'(v);
      end
      calm = (i >= TOTAL_JOBS - CALM_JOBS);
      s_tdata  <= S_TDATA_W'(row.value);
      s_tuser  <= row.mode;
      s_tvalid <= 1'b1;
      do @(posedge clk_i); while (!s_axis_tready_o);
      if (row.typed) due_words.push_back(row.word);
      else trial_divide(row.mode, row.value);
      jobs_taken++;
      @(negedge clk_i);
      if (!calm && $urandom_range(0, 3) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
      end
    end
    s_tvalid <= 1'b0;

    while (due_words.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);   // catch stray words
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Word checker with random back-pressure and one long hold-off that fills
  // the block and stalls its input.
  initial begin : receiver
    int unsigned  stall;
    bit           held;
    factor_word_t got;
    factor_word_t want;
    stall = 0;
    held  = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && jobs_taken >= HOLD_AT) begin
        held  = 1'b1;
        stall = HOLD_CYCLES;
      end else if (stall == 0 && !calm && $urandom_range(0, 5) == 0) begin
        stall = $urandom_range(1, 9);
      end
      m_tready <= (stall == 0);
      if (stall > 0) stall--;
      @(posedge clk_i);
      if (m_axis_tvalid_o && m_tready) begin
        got = '{m_axis_tdata_o[FACTOR_W-1:0], m_axis_tuser_o,
                m_axis_tdata_o[FACTOR_W], m_axis_tlast_o};
        if (due_words.size() == 0) begin
          errors++;
          $display("%0t: word with none due: factor=%0d found=%0b is_prime=%0b last=%0b",
                   $time, got.factor, got.found, got.is_prime, got.last);
        end else begin
          want = due_words.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch exp factor=%0d found=%0b is_prime=%0b last=%0b,",
                     $time, want.factor, want.found, want.is_prime, want.last,
                     " got factor=%0d found=%0b is_prime=%0b last=%0b",
                     got.factor, got.found, got.is_prime, got.last);
          end
        end
      end
    end
  end

endmodule
